// ===== hdl/iwhm_pkg.sv =====
`timescale 1ns / 1ps

package iwhm_pkg;

  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DELTA_W = 64;
  localparam int unsigned PROD_W  = 68;
  localparam int unsigned RUN_W   = 16;
  localparam int unsigned THR_W   = 32;

  localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;

  localparam logic [1:0] REG_DISK_NEED  = 2'd0;
  localparam logic [1:0] REG_CACHE_NEED = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;

  localparam logic [15:0] DISK_NEED_RST  = 16'd3;
  localparam logic [15:0] CACHE_NEED_RST = 16'd5;
  localparam logic [31:0] THRESHOLD_RST  = 32'd4096;

  typedef enum logic [1:0] {
    CLASS_IDLE  = 2'd0,
    CLASS_CACHE = 2'd1,
    CLASS_DISK  = 2'd2,
    CLASS_MIXED = 2'd3
  } class_t;

  typedef struct packed {
    logic             left_powersave;
    logic             entered_powersave;
    logic             powersave_on;
    logic [RUN_W-1:0] cache_run;
    logic [RUN_W-1:0] disk_run;
    class_t           window_class;
  } result_t;

endpackage

// ===== hdl/iwhm_classify.sv =====
`timescale 1ns / 1ps

module iwhm_classify (
  input  logic [iwhm_pkg::DELTA_W-1:0] requested_delta,
  input  logic [iwhm_pkg::DELTA_W-1:0] fetched_delta,
  input  logic [iwhm_pkg::THR_W-1:0]   activity_threshold,
  output iwhm_pkg::class_t             window_class
);
  import iwhm_pkg::*;

  logic [DELTA_W-1:0] thr;
  logic               req_low;
  logic               fet_low;
  logic [PROD_W-1:0]  fet_x5;
  logic [PROD_W-1:0]  req_x3;
  logic [PROD_W-1:0]  fet_x10;
  logic [PROD_W-1:0]  req_x1;

  assign thr     = {{(DELTA_W-THR_W){1'b0}}, activity_threshold};
  assign req_low = requested_delta < thr;
  assign fet_low = fetched_delta < thr;

  // exact ratio tests by shift-and-add
  assign fet_x5  = {4'b0, fetched_delta} + {2'b0, fetched_delta, 2'b0};
  assign req_x3  = {4'b0, requested_delta} + {3'b0, requested_delta, 1'b0};
  assign fet_x10 = {3'b0, fetched_delta, 1'b0} + {1'b0, fetched_delta, 3'b0};
  assign req_x1  = {4'b0, requested_delta};

  always_comb begin
    if (req_low && fet_low) begin
      window_class = CLASS_IDLE;
    end else if (fet_low) begin
      window_class = CLASS_CACHE;
    end else if (requested_delta == '0) begin
      window_class = CLASS_CACHE;
    end else if (fet_x5 >= req_x3) begin
      window_class = CLASS_DISK;
    end else if (req_x1 >= fet_x10) begin
      window_class = CLASS_CACHE;
    end else begin
      window_class = CLASS_MIXED;
    end
  end

endmodule

// ===== hdl/io_window_hysteresis_mode_switch_unit.sv =====
`timescale 1ns / 1ps
// path: an accepted word is held as deltas in the input register, its result then in the output register on m_tvalid
// throughput: one word per cycle unless m_tready stalls the output; input and output registers part the two sides
// invalid samples are dropped; the first valid sample only primes the stored counters, no result
// reset (rst, synchronous, active high) clears the stored counters, streaks and mode
// and loads the register defaults: disk 3, cache 5, threshold 4096

module io_window_hysteresis_mode_switch_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [127:0]                s_tdata,  // requested_total, fetched_total
  input  logic                        s_tuser,  // sample_ok
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // window_class, disk_run, cache_run, powersave_on, entered_powersave, left_powersave
  output logic [39:0]                 m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iwhm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import iwhm_pkg::*;

  logic [15:0]        disk_goal;
  logic [15:0]        cache_goal;
  logic [THR_W-1:0]   threshold;

  logic [DELTA_W-1:0] last_requested;
  logic [DELTA_W-1:0] last_fetched;
  logic               primed;

  logic               delta_valid;
  logic [DELTA_W-1:0] requested_delta;
  logic [DELTA_W-1:0] fetched_delta;

  logic [RUN_W-1:0]   disk_count;
  logic [RUN_W-1:0]   cache_count;
  logic               saving_mode;
  logic [RUN_W-1:0]   disk_count_next;
  logic [RUN_W-1:0]   cache_count_next;
  logic               saving_mode_next;
  logic               entered;
  logic               left;
  logic               mode_mid;

  logic               out_valid;
  result_t            result;
  result_t            result_next;
  class_t             cls;

  logic               in_fire;
  logic               advance;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_goal  <= DISK_NEED_RST;
      cache_goal <= CACHE_NEED_RST;
      threshold  <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DISK_NEED:  disk_goal  <= pwdata[15:0];
        REG_CACHE_NEED: cache_goal <= pwdata[15:0];
        REG_THRESHOLD:  threshold  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DISK_NEED:  prdata = {16'b0, disk_goal};
      REG_CACHE_NEED: prdata = {16'b0, cache_goal};
      REG_THRESHOLD:  prdata = threshold;
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign advance  = !out_valid || m_tready;
  assign s_tready = !delta_valid || advance;
  assign in_fire  = s_tvalid && s_tready;

  // input stage: deltas against the previous valid sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_requested <= '0;
      last_fetched   <= '0;
      primed         <= 1'b0;
      delta_valid    <= 1'b0;
    end else begin
      if (in_fire && s_tuser) begin
        last_requested <= s_tdata[63:0];
        last_fetched   <= s_tdata[127:64];
        primed         <= 1'b1;
      end
      if (in_fire && s_tuser && primed) begin
        delta_valid <= 1'b1;
      end else if (advance) begin
        delta_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_tuser && primed) begin
      requested_delta <= s_tdata[63:0] - last_requested;
      fetched_delta   <= s_tdata[127:64] - last_fetched;
    end
  end

  iwhm_classify u_classify (
    .requested_delta    (requested_delta),
    .fetched_delta      (fetched_delta),
    .activity_threshold (threshold),
    .window_class       (cls)
  );

  // streaks and mode
  always_comb begin
    disk_count_next  = disk_count;
    cache_count_next = cache_count;
    case (cls)
      CLASS_DISK: begin
        disk_count_next  = (disk_count < RUN_MAX) ? disk_count + 1'b1 : disk_count;
        cache_count_next = '0;
      end
      CLASS_CACHE: begin
        cache_count_next = (cache_count < RUN_MAX) ? cache_count + 1'b1 : cache_count;
        disk_count_next  = '0;
      end
      CLASS_MIXED: begin
        disk_count_next  = '0;
        cache_count_next = '0;
      end
      default: ;
    endcase
    entered          = !saving_mode && (disk_count_next >= disk_goal);
    mode_mid         = saving_mode || entered;
    left             = mode_mid && (cache_count_next >= cache_goal);
    saving_mode_next = mode_mid && !left;

    result_next.window_class      = cls;
    result_next.disk_run          = disk_count_next;
    result_next.cache_run         = cache_count_next;
    result_next.powersave_on      = saving_mode_next;
    result_next.entered_powersave = entered;
    result_next.left_powersave    = left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count  <= '0;
      cache_count <= '0;
      saving_mode <= 1'b0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= delta_valid;
      if (delta_valid) begin
        disk_count  <= disk_count_next;
        cache_count <= cache_count_next;
        saving_mode <= saving_mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && delta_valid) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b0, result};

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("result valid right after reset");

  a_delta_needs_prime: assert property (@(posedge clk) disable iff (rst)
    delta_valid |-> primed) else $error("delta formed before priming");

  a_streaks_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.disk_run == '0 || result.cache_run == '0))
    else $error("disk and cache streaks both running");

  a_mode_tracks_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.powersave_on == saving_mode))
    else $error("reported mode differs from held mode");

  a_enter_sets_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.entered_powersave && !result.left_powersave) |->
      result.powersave_on) else $error("entered without powersave set");

endmodule
